[rtl/mbhr_pkg.sv]
// ----------------------------------------------------------------------------
// mbhr_pkg
// Shared types and constants of the holding-register engine.
// ----------------------------------------------------------------------------
package mbhr_pkg;

    // Data path widths
    localparam int WORD_W    = 10;   // stored channel value
    localparam int LANES     = 4;    // data and read lanes of one request
    localparam int LANE_W    = 2;    // index of a lane
    localparam int START_W   = 4;    // start channel, CHANNELS is at most 16
    localparam int QTY_W     = 5;    // checked quantity, at most 16
    localparam int RBYTES_W  = 4;
    localparam int LIMIT_W   = 16;
    localparam int QUEUE_DEPTH = 2;

    // Function codes of a request
    localparam logic [1:0] OP_READ         = 2'd0;
    localparam logic [1:0] OP_WRITE_SINGLE = 2'd1;
    localparam logic [1:0] OP_WRITE_MULTI  = 2'd2;
    localparam logic [1:0] OP_UNUSED       = 2'd3;

    // Configuration register indexes
    localparam logic CFG_READ_LIMIT  = 1'b0;
    localparam logic CFG_WRITE_LIMIT = 1'b1;

    localparam logic [LIMIT_W-1:0] READ_LIMIT_RST  = 16'd125;
    localparam logic [LIMIT_W-1:0] WRITE_LIMIT_RST = 16'd123;

    // Frame length rules
    localparam logic [7:0] READ_MIN_FRAME   = 8'd8;
    localparam logic [7:0] SINGLE_FRAME     = 8'd8;
    localparam logic [7:0] MULTI_MIN_FRAME  = 8'd9;
    localparam logic [8:0] MULTI_FRAME_OVH  = 9'd9;

    typedef enum logic [1:0] {
        EXC_NONE  = 2'd0,
        EXC_VALUE = 2'd1,
        EXC_ADDR  = 2'd2
    } exc_t;

    // One classified request, passed from the front end to the back end
    typedef struct packed {
        exc_t                               exc;
        logic                               do_read;
        logic                               do_write;
        logic [START_W-1:0]                 start;
        logic [QTY_W-1:0]                   qty;
        logic [RBYTES_W-1:0]                read_bytes;
        logic [LANES-1:0][WORD_W-1:0]       vals;
    } cmd_t;

endpackage

[rtl/mbhr_req_if.sv]
// ----------------------------------------------------------------------------
// mbhr_req_if
// Request channel: valid/ready handshake with one parsed request.
// ----------------------------------------------------------------------------
interface mbhr_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [7:0]         frame_len;
    logic [7:0]         addr_hi;
    logic [7:0]         addr_lo;
    logic [15:0]        quantity;
    logic [7:0]         byte_count;
    logic signed [15:0] value0;
    logic signed [15:0] value1;
    logic signed [15:0] value2;
    logic signed [15:0] value3;

    modport source
    (
        output valid, op, frame_len, addr_hi, addr_lo, quantity, byte_count,
               value0, value1, value2, value3,
        input  ready
    );

    modport sink
    (
        input  valid, op, frame_len, addr_hi, addr_lo, quantity, byte_count,
               value0, value1, value2, value3,
        output ready
    );
endinterface

[rtl/mbhr_rsp_if.sv]
// ----------------------------------------------------------------------------
// mbhr_rsp_if
// Response channel: valid/ready handshake with one result.
// ----------------------------------------------------------------------------
interface mbhr_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] exception;
    logic [3:0] read_bytes;
    logic [9:0] word0;
    logic [9:0] word1;
    logic [9:0] word2;
    logic [9:0] word3;

    modport source
    (
        output valid, exception, read_bytes, word0, word1, word2, word3,
        input  ready
    );

    modport sink
    (
        input  valid, exception, read_bytes, word0, word1, word2, word3,
        output ready
    );
endinterface

[rtl/mbhr_front.sv]
// ----------------------------------------------------------------------------
// mbhr_front
// Accept requests, run the value and address checks, clamp the data words
// and push one classified command per request, the unused code apart, into the queue.
// ----------------------------------------------------------------------------
module mbhr_front #(
    parameter int CHANNELS  = 4,
    parameter int MAX_VALUE = 1023
)
(
    mbhr_req_if.sink                          req,
    input  logic [mbhr_pkg::LIMIT_W-1:0]      read_limit,
    input  logic [mbhr_pkg::LIMIT_W-1:0]      write_limit,
    input  logic                              q_ready,
    output logic                              q_push,
    output mbhr_pkg::cmd_t                    q_cmd
);
    import mbhr_pkg::*;

    localparam logic [16:0] CH_17  = 17'(CHANNELS);
    localparam logic [15:0] MAX_16 = 16'(MAX_VALUE);

    logic signed [15:0] raw [LANES];
    logic               val_bad;
    logic               addr_bad;
    logic               range_bad;
    logic [16:0]        end_addr;

    function automatic logic [WORD_W-1:0] clamp_word(input logic signed [15:0] v);
        logic [WORD_W-1:0] r;
        if (v[15])
            r = '0;
        else if (16'(v) > MAX_16)
            r = MAX_16[WORD_W-1:0];
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

    assign raw[0] = req.value0;
    assign raw[1] = req.value1;
    assign raw[2] = req.value2;
    assign raw[3] = req.value3;

    assign end_addr  = {9'd0, req.addr_lo} + {1'b0, req.quantity};
    assign range_bad = (req.addr_hi != 8'd0) || ({9'd0, req.addr_lo} >= CH_17)
                       || (end_addr > CH_17);

    always_comb
    begin
        val_bad  = 1'b0;
        addr_bad = 1'b0;
        unique case (req.op)
            OP_READ:
            begin
                val_bad  = (req.frame_len < READ_MIN_FRAME) || (req.quantity == 16'd0)
                           || (req.quantity > read_limit);
                addr_bad = range_bad;
            end
            OP_WRITE_SINGLE:
            begin
                val_bad  = (req.frame_len != SINGLE_FRAME);
                addr_bad = (req.addr_hi != 8'd0) || ({9'd0, req.addr_lo} >= CH_17);
            end
            OP_WRITE_MULTI:
            begin
                val_bad  = (req.frame_len < MULTI_MIN_FRAME) || (req.quantity == 16'd0)
                           || (req.quantity > write_limit)
                           || ({9'd0, req.byte_count} != {req.quantity, 1'b0})
                           || ({1'b0, req.frame_len}
                               != ({1'b0, req.byte_count} + MULTI_FRAME_OVH));
                addr_bad = range_bad;
            end
            default:
            begin
                val_bad  = 1'b0;
                addr_bad = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        q_cmd.exc = val_bad ? EXC_VALUE : (addr_bad ? EXC_ADDR : EXC_NONE);
        q_cmd.do_read    = (req.op == OP_READ) && (q_cmd.exc == EXC_NONE);
        q_cmd.do_write   = (req.op != OP_READ) && (q_cmd.exc == EXC_NONE);
        q_cmd.start      = req.addr_lo[START_W-1:0];
        // write single touches exactly one channel
        q_cmd.qty        = (req.op == OP_WRITE_SINGLE) ? QTY_W'(1) : req.quantity[QTY_W-1:0];
        q_cmd.read_bytes = q_cmd.do_read ? {req.quantity[RBYTES_W-2:0], 1'b0} : '0;
        for (int p = 0; p < LANES; p++)
        begin
            q_cmd.vals[p] = clamp_word(raw[p]);
        end
    end

    // Unused function code is taken and dropped
    assign req.ready = q_ready;
    assign q_push    = req.valid && q_ready && (req.op != OP_UNUSED);

endmodule

[rtl/mbhr_queue.sv]
// ----------------------------------------------------------------------------
// mbhr_queue
// Two-entry command queue between front end and back end.
// ----------------------------------------------------------------------------
module mbhr_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mbhr_pkg::cmd_t  push_cmd,
    output logic            ready,
    input  logic            pop,
    output logic            valid,
    output mbhr_pkg::cmd_t  head_cmd
);
    import mbhr_pkg::*;

    cmd_t        entry_reg [QUEUE_DEPTH];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign ready    = (count_reg != 2'(QUEUE_DEPTH));
    assign valid    = (count_reg != 2'd0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/mbhr_back.sv]
// ----------------------------------------------------------------------------
// mbhr_back
// Execute classified commands on the channel bank and hold the result in
// the output register until the response is taken.
// ----------------------------------------------------------------------------
module mbhr_back #(
    parameter int CHANNELS = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  mbhr_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    mbhr_rsp_if.source      rsp
);
    import mbhr_pkg::*;

    localparam int FLAT_W = (CHANNELS + LANES) * WORD_W;

    logic [WORD_W-1:0]              chan_reg  [CHANNELS];
    logic [WORD_W-1:0]              chan_next [CHANNELS];
    logic [FLAT_W-1:0]              flat;
    logic [FLAT_W-1:0]              window;
    logic [7:0]                     shift_amt;
    logic [LANES-1:0][WORD_W-1:0]   words;

    logic                           out_valid_reg;
    exc_t                           exc_reg;
    logic [RBYTES_W-1:0]            rbytes_reg;
    logic [LANES-1:0][WORD_W-1:0]   words_reg;

    assign q_pop = q_valid && (!out_valid_reg || rsp.ready);

    // Read window: slide the bank down so the start channel sits in lane 0
    always_comb
    begin
        flat = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            flat[c*WORD_W +: WORD_W] = chan_reg[c];
        end
        shift_amt = 8'(q_cmd.start) * 8'(WORD_W);
        window    = flat >> shift_amt;
        for (int p = 0; p < LANES; p++)
        begin
            if (q_cmd.do_read && (QTY_W'(p) < q_cmd.qty))
                words[p] = window[p*WORD_W +: WORD_W];
            else
                words[p] = '0;
        end
    end

    // Write window: channels from start up to start + qty - 1; beyond the
    // four data lanes they store zero
    always_comb
    begin
        logic [QTY_W-1:0] off;
        for (int c = 0; c < CHANNELS; c++)
        begin
            off          = QTY_W'(c) - {1'b0, q_cmd.start};
            chan_next[c] = chan_reg[c];
            if (q_cmd.do_write && (QTY_W'(c) >= {1'b0, q_cmd.start}) && (off < q_cmd.qty))
            begin
                if (off < QTY_W'(LANES))
                    chan_next[c] = q_cmd.vals[off[LANE_W-1:0]];
                else
                    chan_next[c] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                chan_reg[c] <= '0;
            end
        end
        else
        begin
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    chan_reg[c] <= chan_next[c];
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            exc_reg    <= q_cmd.exc;
            rbytes_reg <= q_cmd.read_bytes;
            words_reg  <= words;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.exception  = exc_reg;
    assign rsp.read_bytes = rbytes_reg;
    assign rsp.word0      = words_reg[0];
    assign rsp.word1      = words_reg[1];
    assign rsp.word2      = words_reg[2];
    assign rsp.word3      = words_reg[3];

endmodule

[rtl/modbus_holding_register_engine_unit.sv]
// ----------------------------------------------------------------------------
// modbus_holding_register_engine_unit
// Holding-register engine for a bank of analog output channels.
//
// Flow: an accepted request is written into the queue, then the back end
//   registers its result in the output register, held until it is taken.
// Throughput: one request per cycle while responses are taken; the
//   back end serves each request with the four-lane read and write window.
// Reset: channel values clear to zero, read limit to 125, write limit to 123;
//   queue and output register come up empty.
// ----------------------------------------------------------------------------
module modbus_holding_register_engine_unit #(
    parameter int CHANNELS  = 4,
    parameter int MAX_VALUE = 1023
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    mbhr_req_if.sink                      req,
    mbhr_rsp_if.source                    rsp,
    input  logic                          cfg_we,
    input  logic                          cfg_idx,
    input  logic [mbhr_pkg::LIMIT_W-1:0]  cfg_data
);
    import mbhr_pkg::*;

    // Quantity limits: the user must write them only while the engine is idle; the block does not enforce it
    logic [LIMIT_W-1:0] read_limit_reg;
    logic [LIMIT_W-1:0] write_limit_reg;

    // Front end to queue
    logic   push;
    logic   q_ready;
    cmd_t   push_cmd;

    // Queue to back end
    logic   q_valid;
    logic   q_pop;
    cmd_t   head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_limit_reg  <= READ_LIMIT_RST;
            write_limit_reg <= WRITE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_READ_LIMIT:  read_limit_reg  <= cfg_data;
                CFG_WRITE_LIMIT: write_limit_reg <= cfg_data;
                default:         read_limit_reg  <= read_limit_reg;
            endcase
        end
    end

    // Classify each request: checks in priority order, clamp the data words
    mbhr_front #(
        .CHANNELS  (CHANNELS),
        .MAX_VALUE (MAX_VALUE)
    ) u_front
    (
        .req         (req),
        .read_limit  (read_limit_reg),
        .write_limit (write_limit_reg),
        .q_ready     (q_ready),
        .q_push      (push),
        .q_cmd       (push_cmd)
    );

    // Decouple the two sides so the front keeps taking requests while a
    // result waits at the output
    mbhr_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_cmd (head_cmd)
    );

    // Apply writes to the channel bank, gather read words, hold the result
    mbhr_back #(
        .CHANNELS (CHANNELS)
    ) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the holding-register engine. Requests go in from a
// queue through a bursty driver, responses are taken by a stalling receiver
// and compared field by field against an in-bench register-bank model.
// ----------------------------------------------------------------------------
module tb_top;
    import mbhr_pkg::*;

    localparam int CHANNEL_COUNT = 4;
    localparam int MAX_LEVEL     = 1023;
    localparam int PHASE_COUNT   = 5;
    localparam int PHASE_ITEMS   = 95;
    localparam int DRAIN_CYCLES  = 4;     // settle margin after the last response
    localparam int LONG_HOLD     = 48;    // receiver hold-off, in cycles

    // One parsed request as the driver presents it
    typedef struct {
        logic [1:0]         op;
        logic [7:0]         frame_len;
        logic [7:0]         addr_hi;
        logic [7:0]         addr_lo;
        logic [15:0]        quantity;
        logic [7:0]         byte_count;
        logic signed [15:0] vals [4];
    } request_t;

    // One response as the engine should return it
    typedef struct {
        exc_t       exception;
        logic [3:0] read_bytes;
        logic [9:0] words [4];
    } response_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_idx;
    logic [LIMIT_W-1:0]  cfg_data;

    mbhr_req_if req_ch();
    mbhr_rsp_if rsp_ch();

    modbus_holding_register_engine_unit #(
        .CHANNELS  (CHANNEL_COUNT),
        .MAX_VALUE (MAX_LEVEL)
    )
    dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench state: register-bank model, request backlog, expected responses
    // ------------------------------------------------------------------------
    logic [9:0]          channel_level [CHANNEL_COUNT];
    logic [LIMIT_W-1:0]  read_cap;
    logic [LIMIT_W-1:0]  write_cap;

    request_t            request_backlog [$];
    response_t           expected_responses [$];

    int unsigned         mismatches;
    int unsigned         burst_left;
    int unsigned         gap_left;
    logic                offer_next;

    // Receiver stall pattern and the long hold-off
    logic [7:0]          stall_pattern;
    int unsigned         pattern_age;
    int unsigned         hold_left;
    bit                  hold_armed;
    logic                ready_next;

    logic [9:0]          seen_word [4];
    response_t           wanted;

    // 10 ns clock: low half, then high half
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model helpers
    // ------------------------------------------------------------------------

    // Saturate a signed data word into the 10-bit channel range
    function automatic logic [9:0] clamp_level(input logic signed [15:0] v);
        if (v < 0)
            return '0;
        if (v > MAX_LEVEL)
            return 10'(MAX_LEVEL);
        return v[9:0];
    endfunction

    // Work out the response of one request and apply its writes to the model.
    // Returns 0 for the unused function code, which yields no response.
    function automatic bit resolve_request(input request_t r, output response_t o);
        int unsigned lo;
        int unsigned qty;
        int unsigned flen;
        int unsigned bcnt;
        bit          span_bad;
        o.exception  = EXC_NONE;
        o.read_bytes = '0;
        for (int i = 0; i < 4; i++)
            o.words[i] = '0;
        if (r.op == OP_UNUSED)
            return 1'b0;
        lo       = r.addr_lo;
        qty      = r.quantity;
        flen     = r.frame_len;
        bcnt     = r.byte_count;
        // Start plus count must fit inside the bank
        span_bad = (r.addr_hi != 0) || (lo >= CHANNEL_COUNT) || (lo + qty > CHANNEL_COUNT);
        case (r.op)
            OP_READ:
            begin
                if (flen < READ_MIN_FRAME || qty == 0 || qty > read_cap)
                    o.exception = EXC_VALUE;
                else if (span_bad)
                    o.exception = EXC_ADDR;
                else
                begin
                    o.read_bytes = 4'(qty * 2);
                    for (int unsigned p = 0; p < qty && p < 4; p++)
                        o.words[p] = channel_level[lo + p];
                end
            end
            OP_WRITE_SINGLE:
            begin
                if (flen != SINGLE_FRAME)
                    o.exception = EXC_VALUE;
                else if (r.addr_hi != 0 || lo >= CHANNEL_COUNT)
                    o.exception = EXC_ADDR;
                else
                    channel_level[lo] = clamp_level(r.vals[0]);
            end
            default:
            begin
                // Byte count is compared at full width, so 2*qty may exceed 255
                if (flen < MULTI_MIN_FRAME || qty == 0 || qty > write_cap ||
                    bcnt != qty * 2 || flen != bcnt + MULTI_FRAME_OVH)
                    o.exception = EXC_VALUE;
                else if (span_bad)
                    o.exception = EXC_ADDR;
                else
                begin
                    for (int unsigned p = 0; p < qty; p++)
                        channel_level[lo + p] = (p < 4) ? clamp_level(r.vals[p]) : '0;
                end
            end
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Data word biased toward the clamp edges
    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, MAX_LEVEL));
            2: return 16'($urandom_range(MAX_LEVEL - 30, MAX_LEVEL + 30));
            3: return -16'sd1 * 16'($urandom_range(1, 40));
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return -16'sd32768;
                    1: return 16'sd32767;
                    2: return 16'sd0;
                    default: return -16'sd1;
                endcase
            end
        endcase
    endfunction

    // Mostly well-formed requests with random content; the rest are broken
    // in one field or are plain noise
    function automatic request_t random_request();
        request_t    r;
        int unsigned lo;
        int unsigned qty;
        case ($urandom_range(0, 2))
            0: r.op = OP_READ;
            1: r.op = OP_WRITE_SINGLE;
            default: r.op = OP_WRITE_MULTI;
        endcase
        lo           = $urandom_range(0, CHANNEL_COUNT - 1);
        qty          = $urandom_range(1, CHANNEL_COUNT - lo);
        r.addr_hi    = '0;
        r.addr_lo    = 8'(lo);
        r.quantity   = 16'(qty);
        r.byte_count = 8'(qty * 2);
        for (int i = 0; i < 4; i++)
            r.vals[i] = pick_value();
        if (r.op == OP_READ)
            r.frame_len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8, 255))
                                                      : READ_MIN_FRAME;
        else if (r.op == OP_WRITE_SINGLE)
        begin
            // Count fields mean nothing to a single write: scramble them
            r.frame_len  = SINGLE_FRAME;
            r.quantity   = 16'($urandom);
            r.byte_count = 8'($urandom);
        end
        else
            r.frame_len = 8'(qty * 2 + MULTI_FRAME_OVH);

        case ($urandom_range(0, 9))
            0:
            begin
                r.op         = 2'($urandom);
                r.frame_len  = 8'($urandom);
                r.addr_hi    = 8'($urandom);
                r.addr_lo    = 8'($urandom);
                r.quantity   = 16'($urandom);
                r.byte_count = 8'($urandom);
            end
            1:
            begin
                case ($urandom_range(0, 5))
                    0: r.frame_len  = 8'($urandom);
                    1: r.addr_hi    = 8'($urandom_range(1, 255));
                    2: r.addr_lo    = 8'($urandom);
                    3: r.quantity   = 16'($urandom);
                    4: r.byte_count = 8'($urandom);
                    default: r.quantity = '0;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic queue_request(input logic [1:0] op, input logic [7:0] flen,
                                 input logic [7:0] ahi, input logic [7:0] alo,
                                 input logic [15:0] qty, input logic [7:0] bcnt,
                                 input logic signed [15:0] v0, input logic signed [15:0] v1,
                                 input logic signed [15:0] v2, input logic signed [15:0] v3);
        request_t r;
        r.op         = op;
        r.frame_len  = flen;
        r.addr_hi    = ahi;
        r.addr_lo    = alo;
        r.quantity   = qty;
        r.byte_count = bcnt;
        r.vals[0]    = v0;
        r.vals[1]    = v1;
        r.vals[2]    = v2;
        r.vals[3]    = v3;
        request_backlog.push_back(r);
    endtask

    // Wait until the engine holds nothing: backlog empty, no request on the
    // wire, every response back, then let the pipeline settle in case the
    // last request was an unused code that produced no response.
    task automatic drain_engine();
        while (request_backlog.size() != 0 || req_ch.valid || expected_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one limit register; only called while the engine is idle
    task automatic write_limit(input logic idx, input logic [LIMIT_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_READ_LIMIT)
            read_cap = value;
        else
            write_cap = value;
    endtask

    // ------------------------------------------------------------------------
    // Driver: present requests from the backlog in bursts with gaps. Hold the
    // payload while the engine stalls; predict at the accepting edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        response_t outcome;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                if (resolve_request(request_backlog[0], outcome))
                    expected_responses.push_back(outcome);
                void'(request_backlog.pop_front());
            end
            // A stalled request stays on the wire untouched
            if (!(req_ch.valid && !req_ch.ready))
            begin
                offer_next = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (request_backlog.size() > 0)
                begin
                    offer_next = 1'b1;
                    req_ch.op         <= request_backlog[0].op;
                    req_ch.frame_len  <= request_backlog[0].frame_len;
                    req_ch.addr_hi    <= request_backlog[0].addr_hi;
                    req_ch.addr_lo    <= request_backlog[0].addr_lo;
                    req_ch.quantity   <= request_backlog[0].quantity;
                    req_ch.byte_count <= request_backlog[0].byte_count;
                    req_ch.value0     <= request_backlog[0].vals[0];
                    req_ch.value1     <= request_backlog[0].vals[1];
                    req_ch.value2     <= request_backlog[0].vals[2];
                    req_ch.value3     <= request_backlog[0].vals[3];
                    // End of burst: pick the next burst and the gap before it.
                    // A quarter of the gaps are empty, giving unbroken streams.
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                req_ch.valid <= offer_next;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready follows a rotating stall pattern that is reloaded when
    // its random age runs out (all-ready among the choices). Once armed and a
    // request is on offer, hold ready low for the LONG_HOLD hold-off so the engine fills.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_pattern = 8'hff;
            pattern_age   = 0;
            hold_left     = 0;
        end
        else
        begin
            if (hold_left == 0 && hold_armed && req_ch.valid)
            begin
                hold_left  = LONG_HOLD;
                hold_armed = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                if (pattern_age == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: stall_pattern = 8'hff;
                        1: stall_pattern = 8'($urandom);
                        2: stall_pattern = 8'($urandom) | 8'($urandom);
                        default: stall_pattern = 8'($urandom) & 8'($urandom);
                    endcase
                    pattern_age = $urandom_range(8, 40);
                end
                else
                    pattern_age--;
                ready_next    = stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
            end
            rsp_ch.ready <= ready_next;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare every accepted response with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen_word[0] = rsp_ch.word0;
            seen_word[1] = rsp_ch.word1;
            seen_word[2] = rsp_ch.word2;
            seen_word[3] = rsp_ch.word3;
            if (expected_responses.size() == 0)
            begin
                $error("response with no request outstanding");
                mismatches++;
            end
            else
            begin
                wanted = expected_responses.pop_front();
                if (rsp_ch.exception !== wanted.exception)
                begin
                    $error("exception: expected %0d, got %0d", wanted.exception,
                           rsp_ch.exception);
                    mismatches++;
                end
                if (rsp_ch.read_bytes !== wanted.read_bytes)
                begin
                    $error("read_bytes: expected %0d, got %0d", wanted.read_bytes,
                           rsp_ch.read_bytes);
                    mismatches++;
                end
                for (int i = 0; i < 4; i++)
                begin
                    if (seen_word[i] !== wanted.words[i])
                    begin
                        $error("word%0d: expected %0d, got %0d", i, wanted.words[i],
                               seen_word[i]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed requests at reset limits, then random phases
    // under different limit settings, draining fully between phases.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [LIMIT_W-1:0] read_caps  [PHASE_COUNT];
        logic [LIMIT_W-1:0] write_caps [PHASE_COUNT];

        // Widest limits, zero limits, single register, small, back to reset
        read_caps  = '{16'hffff, 16'd0, 16'd1, 16'd3, READ_LIMIT_RST};
        write_caps = '{16'hffff, 16'd0, 16'd1, 16'd2, WRITE_LIMIT_RST};

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_READ_LIMIT;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.op         = OP_READ;
        req_ch.frame_len  = '0;
        req_ch.addr_hi    = '0;
        req_ch.addr_lo    = '0;
        req_ch.quantity   = '0;
        req_ch.byte_count = '0;
        req_ch.value0     = '0;
        req_ch.value1     = '0;
        req_ch.value2     = '0;
        req_ch.value3     = '0;
        rsp_ch.ready      = 1'b0;
        mismatches        = 0;
        hold_armed        = 1'b0;
        read_cap          = READ_LIMIT_RST;
        write_cap         = WRITE_LIMIT_RST;
        for (int c = 0; c < CHANNEL_COUNT; c++)
            channel_level[c] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset limits. Bank reads back zero after reset.
        queue_request(OP_READ, 8'd8, 8'd0, 8'd0, 16'd4, 8'd0, 0, 0, 0, 0);
        // Single writes at the clamp edges, one per channel
        queue_request(OP_WRITE_SINGLE, 8'd8, 8'd0, 8'd0, 16'd0, 8'd0, 16'sd32767, 0, 0, 0);
        queue_request(OP_WRITE_SINGLE, 8'd8, 8'd0, 8'd1, 16'hffff, 8'hff,
                      -16'sd32768, 0, 0, 0);
        queue_request(OP_WRITE_SINGLE, 8'd8, 8'd0, 8'd2, 16'd0, 8'd0, 16'sd1023, 0, 0, 0);
        queue_request(OP_WRITE_SINGLE, 8'd8, 8'd0, 8'd3, 16'd0, 8'd0, 16'sd1024, 0, 0, 0);
        // Longest frame on a read is still legal
        queue_request(OP_READ, 8'd255, 8'd0, 8'd0, 16'd4, 8'd0, 0, 0, 0, 0);
        queue_request(OP_WRITE_MULTI, 8'd17, 8'd0, 8'd0, 16'd4, 8'd8,
                      16'sd5, -16'sd1, 16'sd1022, 16'sd32767);
        queue_request(OP_READ, 8'd8, 8'd0, 8'd3, 16'd1, 8'd0, 0, 0, 0, 0);
        // Read: short frame, zero count, count over the limit
        queue_request(OP_READ, 8'd7, 8'd0, 8'd0, 16'd1, 8'd0, 0, 0, 0, 0);
        queue_request(OP_READ, 8'd8, 8'd0, 8'd0, 16'd0, 8'd0, 0, 0, 0, 0);
        queue_request(OP_READ, 8'd8, 8'd0, 8'd0, 16'd126, 8'd0, 0, 0, 0, 0);
        // Read: count at the limit passes the value check, fails on address
        queue_request(OP_READ, 8'd8, 8'd0, 8'd0, 16'd125, 8'd0, 0, 0, 0, 0);
        queue_request(OP_READ, 8'd8, 8'd255, 8'd0, 16'd1, 8'd0, 0, 0, 0, 0);
        queue_request(OP_READ, 8'd8, 8'd0, 8'd4, 16'd1, 8'd0, 0, 0, 0, 0);
        queue_request(OP_READ, 8'd8, 8'd0, 8'd2, 16'd3, 8'd0, 0, 0, 0, 0);
        // Single write: wrong frame, bad start
        queue_request(OP_WRITE_SINGLE, 8'd9, 8'd0, 8'd0, 16'd0, 8'd0, 16'sd7, 0, 0, 0);
        queue_request(OP_WRITE_SINGLE, 8'd8, 8'd0, 8'd255, 16'd0, 8'd0, 16'sd7, 0, 0, 0);
        queue_request(OP_WRITE_SINGLE, 8'd8, 8'd1, 8'd0, 16'd0, 8'd0, 16'sd7, 0, 0, 0);
        // Multi write: byte count off, frame off, count over limit, short frame
        queue_request(OP_WRITE_MULTI, 8'd14, 8'd0, 8'd0, 16'd2, 8'd5, 16'sd9, 16'sd9, 0, 0);
        queue_request(OP_WRITE_MULTI, 8'd14, 8'd0, 8'd0, 16'd2, 8'd4, 16'sd9, 16'sd9, 0, 0);
        queue_request(OP_WRITE_MULTI, 8'd255, 8'd0, 8'd0, 16'd124, 8'd248, 0, 0, 0, 0);
        queue_request(OP_WRITE_MULTI, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 0, 0, 0, 0);
        // Multi write running past the last channel
        queue_request(OP_WRITE_MULTI, 8'd13, 8'd0, 8'd3, 16'd2, 8'd4, 16'sd9, 16'sd9, 0, 0);
        // Unused function code: dropped without a response
        queue_request(OP_UNUSED, 8'd255, 8'd255, 8'd255, 16'hffff, 8'd255,
                      -16'sd1, -16'sd1, -16'sd1, -16'sd1);
        // Failed writes must have left the bank alone
        queue_request(OP_READ, 8'd8, 8'd0, 8'd0, 16'd4, 8'd0, 0, 0, 0, 0);
        drain_engine();

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            write_limit(CFG_READ_LIMIT, read_caps[ph]);
            write_limit(CFG_WRITE_LIMIT, write_caps[ph]);
            // With the widest limit, a count whose doubled value wraps the
            // byte field must still be refused on the byte count
            if (ph == 0)
                queue_request(OP_WRITE_MULTI, 8'd9, 8'd0, 8'd0, 16'd128, 8'd0, 0, 0, 0, 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                request_backlog.push_back(random_request());
            hold_armed = 1'b1;
            drain_engine();
        end

        if (mismatches == 0)
            $display("modbus_holding_register_engine_unit test passed");
        else
            $display("modbus_holding_register_engine_unit test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("modbus_holding_register_engine_unit test failed");
        $finish;
    end

endmodule
